FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the framebuffer engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, operation codes and sizes shared by the framebuffer engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int SCREEN_WIDTH_DEFAULT  = 256;
  localparam int SCREEN_HEIGHT_DEFAULT = 256;
  localparam int PALETTE_SIZE          = 256;
  localparam int PAL_AW                = 8;
  localparam int OP_W                  = 4;

  localparam logic [OP_W-1:0] OP_PUT_INDEX  = 4'd0;
  localparam logic [OP_W-1:0] OP_PUT_WORD   = 4'd1;
  localparam logic [OP_W-1:0] OP_PUT_CHAN   = 4'd2;
  localparam logic [OP_W-1:0] OP_READ       = 4'd3;
  localparam logic [OP_W-1:0] OP_FILL_INDEX = 4'd4;
  localparam logic [OP_W-1:0] OP_FILL_RGB   = 4'd5;
  localparam logic [OP_W-1:0] OP_SET_ENTRY  = 4'd6;
  localparam logic [OP_W-1:0] OP_RAMP       = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [7:0]      x;
    logic [7:0]      y;
    logic [7:0]      x_end;
    logic [7:0]      y_end;
    logic [7:0]      color_index;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [31:0]     rgb_word;
  } pfe_item_t;

  typedef struct packed {
    logic [7:0]  pixel_index;
    logic [31:0] pixel_rgb;
  } pfe_result_t;

  typedef struct packed {
    logic load;
    logic sw_clr;
    logic sw_inc;
    logic init_wr;
    logic clr_wr;
    logic pal_rd;
    logic pix_wr;
    logic pix_rd;
    logic fill_start;
    logic fill_wr;
    logic pal_set;
    logic ramp_wr;
    logic rp_issue;
  } pfe_cmd_t;

  typedef struct packed {
    logic en;
    logic fill_empty;
    logic fill_last;
    logic sw_last_pix;
    logic sw_last_pal;
    logic sw_last_init;
    logic sw_last_rp;
  } pfe_status_t;

endpackage

FILE: design/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer that steps each item through its datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [pfe_pkg::OP_W-1:0] operation,
  input  pfe_pkg::pfe_status_t     status,
  output pfe_pkg::pfe_cmd_t        cmd,
  output logic                     busy,
  output logic                     done
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PAL     = 4'd2;
  localparam logic [3:0] S_PUT     = 4'd3;
  localparam logic [3:0] S_READ    = 4'd4;
  localparam logic [3:0] S_FILLP   = 4'd5;
  localparam logic [3:0] S_FILL    = 4'd6;
  localparam logic [3:0] S_SET     = 4'd7;
  localparam logic [3:0] S_RAMP    = 4'd8;
  localparam logic [3:0] S_REPAINT = 4'd9;
  localparam logic [3:0] S_CLEAR   = 4'd10;
  localparam logic [3:0] S_RES     = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.sw_last_init) begin
          cmd.sw_clr = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.sw_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cmd.sw_clr = 1'b1;
          unique case (operation)
            pfe_pkg::OP_PUT_INDEX:  state_next = S_PAL;
            pfe_pkg::OP_PUT_WORD:   state_next = S_PUT;
            pfe_pkg::OP_PUT_CHAN:   state_next = S_PUT;
            pfe_pkg::OP_READ:       state_next = S_READ;
            pfe_pkg::OP_FILL_INDEX: state_next = S_FILLP;
            pfe_pkg::OP_FILL_RGB:   state_next = S_FILLP;
            pfe_pkg::OP_SET_ENTRY:  state_next = S_SET;
            pfe_pkg::OP_RAMP:       state_next = S_RAMP;
            pfe_pkg::OP_CLEAR:      state_next = S_CLEAR;
            default:                state_next = S_RES;
          endcase
        end
      end
      S_PAL: begin
        cmd.pal_rd = 1'b1;
        state_next = S_PUT;
      end
      S_PUT: begin
        cmd.pix_wr = 1'b1;
        state_next = S_RES;
      end
      S_READ: begin
        cmd.pix_rd = 1'b1;
        state_next = S_RES;
      end
      S_FILLP: begin
        cmd.pal_rd     = 1'b1;
        cmd.fill_start = 1'b1;
        state_next     = status.fill_empty ? S_RES : S_FILL;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (status.fill_last) begin
          state_next = S_RES;
        end
      end
      S_SET: begin
        cmd.pal_set = 1'b1;
        state_next  = S_RES;
      end
      S_RAMP: begin
        cmd.ramp_wr = 1'b1;
        if (status.sw_last_pal) begin
          cmd.sw_clr = 1'b1;
          state_next = status.en ? S_REPAINT : S_RES;
        end else begin
          cmd.sw_inc = 1'b1;
        end
      end
      S_REPAINT: begin
        cmd.rp_issue = 1'b1;
        if (status.sw_last_rp) begin
          cmd.sw_clr = 1'b1;
          state_next = S_RES;
        end else begin
          cmd.sw_inc = 1'b1;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.sw_last_pix) begin
          cmd.sw_clr = 1'b1;
          state_next = S_RES;
        end else begin
          cmd.sw_inc = 1'b1;
        end
      end
      S_RES: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RES);

endmodule

FILE: design/pfe_datapath.sv
// ----------------------------------------------------------------------------
// pfe_datapath
// Palette, index and color memories with the item, sweep and fill counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_datapath #(
  parameter int SCREEN_WIDTH  = pfe_pkg::SCREEN_WIDTH_DEFAULT,
  parameter int SCREEN_HEIGHT = pfe_pkg::SCREEN_HEIGHT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pfe_pkg::pfe_cmd_t     cmd,
  input  pfe_pkg::pfe_item_t    item,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  output pfe_pkg::pfe_status_t  status,
  output pfe_pkg::pfe_result_t  result
);

  localparam int AW       = (SCREEN_WIDTH < 256) ? SCREEN_WIDTH : 256;
  localparam int AH       = (SCREEN_HEIGHT < 256) ? SCREEN_HEIGHT : 256;
  localparam int NPIX     = AW * AH;
  localparam int PIX_AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int INIT_LEN = (NPIX > pfe_pkg::PALETTE_SIZE) ? NPIX : pfe_pkg::PALETTE_SIZE;
  localparam int SW_LEN   = ((NPIX + 2) > INIT_LEN) ? (NPIX + 2) : INIT_LEN;
  localparam int SW_W     = $clog2(SW_LEN);

  localparam logic [SW_W-1:0] SW_PIX_LAST  = SW_W'(NPIX - 1);
  localparam logic [SW_W-1:0] SW_PAL_LAST  = SW_W'(pfe_pkg::PALETTE_SIZE - 1);
  localparam logic [SW_W-1:0] SW_INIT_LAST = SW_W'(INIT_LEN - 1);
  localparam logic [SW_W-1:0] SW_RP_LAST   = SW_W'(NPIX + 1);
  localparam logic [SW_W-1:0] SW_NPIX      = SW_W'(NPIX);
  localparam logic [SW_W-1:0] SW_NPAL      = SW_W'(pfe_pkg::PALETTE_SIZE);
  localparam logic [7:0]      X_MAX        = 8'(AW - 1);
  localparam logic [7:0]      Y_MAX        = 8'(AH - 1);

  pfe_pkg::pfe_item_t item_q;
  logic               en;
  logic [SW_W-1:0]    sw_cnt;
  logic [7:0]         fx;
  logic [7:0]         fy;
  logic [7:0]         x1c;
  logic [7:0]         y1c;
  logic               on_screen;

  logic [47:0]        pal_mem [pfe_pkg::PALETTE_SIZE];
  logic [7:0]         idx_mem [NPIX];
  logic [31:0]        col_mem [NPIX];
  logic [47:0]        pal_q;
  logic [7:0]         idx_q;
  logic [31:0]        col_q;
  logic [31:0]        pal_rgb;

  logic               rp_go;
  logic               rp_v1;
  logic               rp_v2;
  logic [PIX_AW-1:0]  rp_a1;
  logic [PIX_AW-1:0]  rp_a2;

  logic [7:0]         sel_x;
  logic [7:0]         sel_y;
  logic [16:0]        lin;
  logic [PIX_AW-1:0]  pix_addr;
  logic [PIX_AW-1:0]  sw_pix;
  logic [pfe_pkg::PAL_AW-1:0] sw_pal;
  logic               is_idx_op;

  logic               col_we;
  logic [PIX_AW-1:0]  col_wa;
  logic [31:0]        col_wd;
  logic               idx_we;
  logic [PIX_AW-1:0]  idx_wa;
  logic [7:0]         idx_wd;
  logic               pal_we;
  logic [pfe_pkg::PAL_AW-1:0] pal_wa;
  logic [47:0]        pal_wd;
  logic               pix_re;
  logic [PIX_AW-1:0]  pix_ra;
  logic               pal_re;
  logic [pfe_pkg::PAL_AW-1:0] pal_ra;
  logic [15:0]        ramp_r;
  logic [15:0]        ramp_g;
  logic [15:0]        ramp_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      en     <= 1'b1;
      sw_cnt <= '0;
      rp_v1  <= 1'b0;
      rp_v2  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        en <= cfg_wr_data;
      end
      if (cmd.sw_clr) begin
        sw_cnt <= '0;
      end else if (cmd.sw_inc) begin
        sw_cnt <= sw_cnt + 1'b1;
      end
      rp_v1 <= rp_go;
      rp_v2 <= rp_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.fill_start) begin
      fx <= item_q.x;
      fy <= item_q.y;
    end else if (cmd.fill_wr) begin
      if (fy == y1c) begin
        fy <= item_q.y;
        fx <= fx + 8'd1;
      end else begin
        fy <= fy + 8'd1;
      end
    end
    rp_a1 <= sw_pix;
    rp_a2 <= rp_a1;
  end

  assign x1c       = ({1'b0, item_q.x_end} > {1'b0, X_MAX}) ? X_MAX : item_q.x_end;
  assign y1c       = ({1'b0, item_q.y_end} > {1'b0, Y_MAX}) ? Y_MAX : item_q.y_end;
  assign on_screen = ({1'b0, item_q.x} < 9'(AW)) && ({1'b0, item_q.y} < 9'(AH));
  assign is_idx_op = (item_q.operation == pfe_pkg::OP_PUT_INDEX) ||
                     (item_q.operation == pfe_pkg::OP_FILL_INDEX);

  assign sel_x    = cmd.fill_wr ? fx : item_q.x;
  assign sel_y    = cmd.fill_wr ? fy : item_q.y;
  assign lin      = 17'(sel_y) * 17'(AW) + 17'(sel_x);
  assign pix_addr = lin[PIX_AW-1:0];
  assign sw_pix   = sw_cnt[PIX_AW-1:0];
  assign sw_pal   = sw_cnt[pfe_pkg::PAL_AW-1:0];
  assign rp_go    = cmd.rp_issue && (sw_cnt < SW_NPIX);

  assign pal_rgb = {pal_q[47:32], 16'd0} + {8'd0, pal_q[31:16], 8'd0} + {16'd0, pal_q[15:0]};

  assign ramp_r = 16'(item_q.red) * 16'(sw_pal);
  assign ramp_g = 16'(item_q.green) * 16'(sw_pal);
  assign ramp_b = 16'(item_q.blue) * 16'(sw_pal);

  always_comb begin
    col_we = 1'b0;
    col_wa = pix_addr;
    col_wd = '0;
    idx_we = 1'b0;
    idx_wa = pix_addr;
    idx_wd = item_q.color_index;
    pal_we = 1'b0;
    pal_wa = item_q.color_index;
    pal_wd = {8'd0, item_q.blue, 8'd0, item_q.green, 8'd0, item_q.red};
    priority if (cmd.init_wr) begin
      idx_we = (sw_cnt < SW_NPIX);
      idx_wa = sw_pix;
      idx_wd = '0;
      pal_we = (sw_cnt < SW_NPAL);
      pal_wa = sw_pal;
      pal_wd = '0;
    end else if (cmd.clr_wr) begin
      col_we = 1'b1;
      col_wa = sw_pix;
      idx_we = en;
      idx_wa = sw_pix;
      idx_wd = '0;
    end else if (cmd.pix_wr || cmd.fill_wr) begin
      col_we = on_screen || cmd.fill_wr;
      idx_we = (on_screen || cmd.fill_wr) && en && is_idx_op;
      if (is_idx_op) begin
        col_wd = pal_rgb;
      end else if (item_q.operation == pfe_pkg::OP_PUT_CHAN) begin
        col_wd = {8'd0, item_q.blue, item_q.green, item_q.red};
      end else begin
        col_wd = item_q.rgb_word;
      end
    end else if (rp_v2) begin
      col_we = 1'b1;
      col_wa = rp_a2;
      col_wd = pal_rgb;
    end else if (cmd.ramp_wr) begin
      pal_we = 1'b1;
      pal_wa = sw_pal;
      pal_wd = {ramp_b, ramp_g, ramp_r};
    end else begin
      pal_we = cmd.pal_set;
    end
  end

  assign pix_re = cmd.pix_rd || rp_go;
  assign pix_ra = rp_go ? sw_pix : pix_addr;
  assign pal_re = cmd.pal_rd || rp_v1;
  assign pal_ra = rp_v1 ? idx_q : item_q.color_index;

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    if (pix_re) begin
      col_q <= col_mem[pix_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (idx_we) begin
      idx_mem[idx_wa] <= idx_wd;
    end
    if (pix_re) begin
      idx_q <= idx_mem[pix_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_wa] <= pal_wd;
    end
    if (pal_re) begin
      pal_q <= pal_mem[pal_ra];
    end
  end

  assign status.en           = en;
  assign status.fill_empty   = (item_q.x > x1c) || (item_q.y > y1c);
  assign status.fill_last    = (fx == x1c) && (fy == y1c);
  assign status.sw_last_pix  = (sw_cnt == SW_PIX_LAST);
  assign status.sw_last_pal  = (sw_cnt == SW_PAL_LAST);
  assign status.sw_last_init = (sw_cnt == SW_INIT_LAST);
  assign status.sw_last_rp   = (sw_cnt == SW_RP_LAST);

  assign result.pixel_index =
    (item_q.operation == pfe_pkg::OP_READ && on_screen && en) ? idx_q : 8'd0;
  assign result.pixel_rgb =
    (item_q.operation == pfe_pkg::OP_READ && on_screen) ? col_q : 32'd0;

endmodule

FILE: design/palette_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// palette_framebuffer_engine
// Indexed-color framebuffer with a 256-entry palette and a packed RGB store.
// ----------------------------------------------------------------------------
//  channel   signals                     direction  handshake
//  item      start, busy, item           in         start while busy is low
//  result    done, result                out        one-cycle strobe
//  config    cfg_wr_en, cfg_wr_data      in         write enable, no wait
//
// After reset the block clears its palette and index memory in one sweep with
// busy high. An accepted put by word or channels writes the pixel, a read
// reads it, a put by index reads the palette entry first, an unused code does
// nothing; busy is high through the result cycle. Results cannot be stalled.
// Fills and clears write one pixel per cycle, a ramp one palette entry per
// cycle and then, with the index store on, repaints one pixel per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palette_framebuffer_engine #(
  parameter int SCREEN_WIDTH  = pfe_pkg::SCREEN_WIDTH_DEFAULT,
  parameter int SCREEN_HEIGHT = pfe_pkg::SCREEN_HEIGHT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pfe_pkg::pfe_item_t   item,
  output logic                 done,
  output pfe_pkg::pfe_result_t result,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);

  pfe_pkg::pfe_cmd_t    cmd;
  pfe_pkg::pfe_status_t status;

  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  pfe_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (status),
    .result      (result)
  );

  `ASSERT_SAME(a_done_while_busy, clk, rst, done, busy)
  `ASSERT_NEXT(a_accept_sets_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy)

endmodule

FILE: tb/sv/palette_framebuffer_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_framebuffer_engine_test
// Self-checking bench for the palette framebuffer engine. A shadow copy of the
// palette, index memory and color memory predicts every result. Directed
// items cover the corners and special cases, then random phases alternate the
// index store setting while the sender idles at random in all but one phase.
// ----------------------------------------------------------------------------

module palette_framebuffer_engine_test;
  import pfe_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int PHASES = 5;
  localparam int HOT_PIXELS = 48;
  localparam int REPORT_LIMIT = 30;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd9;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST = 4'd15;

  class pixel_shadow;
    logic [15:0] pal_red[PALETTE_SIZE];
    logic [15:0] pal_green[PALETTE_SIZE];
    logic [15:0] pal_blue[PALETTE_SIZE];
    logic [7:0] index_mem[65536];
    logic [31:0] color_mem[65536];
    bit index_enable;
    pfe_result_t expected_pixels[$];
    int mismatches;
    int reads_noted;

    function new();
      for (int k = 0; k < PALETTE_SIZE; k++) begin
        pal_red[k] = '0;
        pal_green[k] = '0;
        pal_blue[k] = '0;
      end
      for (int a = 0; a < 65536; a++) begin
        index_mem[a] = '0;
        color_mem[a] = '0;
      end
      index_enable = 1'b1;
      mismatches = 0;
      reads_noted = 0;
    endfunction

    function void set_index_enable(bit v);
      index_enable = v;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function logic [31:0] pack_color(logic [31:0] r, logic [31:0] g, logic [31:0] b);
      return (b << 16) + (g << 8) + r;
    endfunction

    function logic [31:0] entry_color(logic [7:0] idx);
      return pack_color({16'd0, pal_red[idx]}, {16'd0, pal_green[idx]},
                        {16'd0, pal_blue[idx]});
    endfunction

    function void paint_index(logic [7:0] px, logic [7:0] py, logic [7:0] idx);
      if (index_enable) index_mem[{py, px}] = idx;
      color_mem[{py, px}] = entry_color(idx);
    endfunction

    function void fill_rect(pfe_item_t it, bit by_index);
      for (int i = int'(it.x); i <= int'(it.x_end); i++) begin
        for (int j = int'(it.y); j <= int'(it.y_end); j++) begin
          if (by_index) paint_index(8'(i), 8'(j), it.color_index);
          else color_mem[{8'(j), 8'(i)}] = it.rgb_word;
        end
      end
    endfunction

    function void note_item(pfe_item_t it);
      pfe_result_t res;
      res = '0;
      case (it.operation)
        OP_PUT_INDEX: paint_index(it.x, it.y, it.color_index);
        OP_PUT_WORD: color_mem[{it.y, it.x}] = it.rgb_word;
        OP_PUT_CHAN: begin
          color_mem[{it.y, it.x}] = pack_color({24'd0, it.red}, {24'd0, it.green},
                                               {24'd0, it.blue});
        end
        OP_READ: begin
          reads_noted++;
          if (index_enable) res.pixel_index = index_mem[{it.y, it.x}];
          res.pixel_rgb = color_mem[{it.y, it.x}];
        end
        OP_FILL_INDEX: fill_rect(it, 1'b1);
        OP_FILL_RGB: fill_rect(it, 1'b0);
        OP_SET_ENTRY: begin
          pal_red[it.color_index] = {8'd0, it.red};
          pal_green[it.color_index] = {8'd0, it.green};
          pal_blue[it.color_index] = {8'd0, it.blue};
        end
        OP_RAMP: begin
          for (int k = 0; k < PALETTE_SIZE; k++) begin
            pal_red[k] = 16'(int'(it.red) * k);
            pal_green[k] = 16'(int'(it.green) * k);
            pal_blue[k] = 16'(int'(it.blue) * k);
          end
          if (index_enable) begin
            for (int a = 0; a < 65536; a++) color_mem[a] = entry_color(index_mem[a]);
          end
        end
        OP_CLEAR: begin
          for (int a = 0; a < 65536; a++) begin
            color_mem[a] = '0;
            if (index_enable) index_mem[a] = '0;
          end
        end
        default: ;
      endcase
      expected_pixels.push_back(res);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("ERROR %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    task check_result(pfe_result_t got);
      pfe_result_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", {got.pixel_index, 24'd0},
                        got.pixel_rgb);
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_index !== want.pixel_index)
          report_mismatch("pixel_index", {24'd0, got.pixel_index},
                          {24'd0, want.pixel_index});
        if (got.pixel_rgb !== want.pixel_rgb)
          report_mismatch("pixel_rgb", got.pixel_rgb, want.pixel_rgb);
      end
    endtask

    task flag_leftovers();
      while (expected_pixels.size() != 0) begin
        void'(expected_pixels.pop_front());
        report_mismatch("result never arrived", 32'd0, 32'd0);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pfe_item_t item = '0;
  logic done;
  pfe_result_t result;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  pixel_shadow book;
  logic [15:0] hot_pixels[$];
  int heavy_left = 5;
  int items_sent = 0;
  int settings_written = 0;
  bit index_on = 1'b1;
  bit sender_idles = 1'b1;

  palette_framebuffer_engine DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) book.check_result(result);
  end

  function automatic logic [15:0] pick_pixel(int reuse_pct);
    if (hot_pixels.size() > 0 && $urandom_range(0, 99) < reuse_pct)
      return hot_pixels[$urandom_range(0, hot_pixels.size() - 1)];
    return 16'($urandom);
  endfunction

  function automatic void remember_pixel(logic [15:0] spot);
    hot_pixels.push_back(spot);
    if (hot_pixels.size() > HOT_PIXELS) void'(hot_pixels.pop_front());
  endfunction

  function automatic pfe_item_t random_item();
    pfe_item_t it;
    int roll;
    int shape;
    it.x = 8'($urandom);
    it.y = 8'($urandom);
    it.x_end = 8'($urandom);
    it.y_end = 8'($urandom);
    it.color_index = 8'($urandom);
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    it.rgb_word = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 18) it.operation = OP_PUT_INDEX;
    else if (roll < 28) it.operation = OP_PUT_WORD;
    else if (roll < 36) it.operation = OP_PUT_CHAN;
    else if (roll < 64) it.operation = OP_READ;
    else if (roll < 72) it.operation = OP_FILL_INDEX;
    else if (roll < 80) it.operation = OP_FILL_RGB;
    else if (roll < 90) it.operation = OP_SET_ENTRY;
    else if (roll < 94) it.operation = OP_RAMP;
    else if (roll < 96) it.operation = OP_CLEAR;
    else it.operation = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    if (it.operation == OP_CLEAR || (it.operation == OP_RAMP && index_on)) begin
      if (heavy_left > 0) heavy_left--;
      else it.operation = OP_READ;
    end
    if ($urandom_range(0, 9) == 0) it.rgb_word = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 1) == 1) it.color_index = 8'($urandom_range(0, 7));
    case (it.operation)
      OP_PUT_INDEX, OP_PUT_WORD, OP_PUT_CHAN: begin
        {it.y, it.x} = pick_pixel(30);
        remember_pixel({it.y, it.x});
      end
      OP_READ: {it.y, it.x} = pick_pixel(75);
      OP_FILL_INDEX, OP_FILL_RGB: begin
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
          it.x = 8'($urandom_range(1, 255));
          it.x_end = 8'($urandom_range(0, int'(it.x) - 1));
        end else if (shape < 18) begin
          it.y = 8'($urandom_range(1, 255));
          it.y_end = 8'($urandom_range(0, int'(it.y) - 1));
        end else if (shape < 30) begin
          it.y_end = it.y + 8'($urandom_range(0, 2));
        end else if (shape < 31 && heavy_left > 0) begin
          heavy_left--;
          it.x = '0;
          it.y = '0;
          it.x_end = '1;
          it.y_end = '1;
        end else begin
          it.x_end = it.x + 8'($urandom_range(0, 7));
          it.y_end = it.y + 8'($urandom_range(0, 7));
        end
        remember_pixel({it.y, it.x});
        remember_pixel({it.y_end, it.x_end});
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic issue_item(input pfe_item_t it);
    while (sender_idles && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    book.note_item(it);
    items_sent++;
  endtask

  task automatic send_directed(input logic [OP_W-1:0] op, input logic [7:0] px, py,
                               pxe, pye, ci, r, g, b, input logic [31:0] w);
    pfe_item_t it;
    it.operation = op;
    it.x = px;
    it.y = py;
    it.x_end = pxe;
    it.y_end = pye;
    it.color_index = ci;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.rgb_word = w;
    issue_item(it);
  endtask

  task automatic set_index_store(input bit v);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.set_index_enable(v);
    index_on = v;
    settings_written++;
  endtask

  initial begin
    pfe_item_t it;
    book = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_index_store(1'b1);

    // The first clear defines every color word before anything is read.
    send_directed(OP_CLEAR, 8'h5a, 8'ha5, 8'h3c, 8'hc3, 8'h99, 8'h66, 8'h0f, 8'hf0, 32'h1234_5678);
    send_directed(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_READ, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, '1);
    send_directed(OP_SET_ENTRY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 32'd0);
    send_directed(OP_SET_ENTRY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h12, 8'h34, 8'h56, 32'd0);
    send_directed(OP_PUT_INDEX, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_READ, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_PUT_INDEX, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_PUT_WORD, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, '1);
    send_directed(OP_READ, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_PUT_CHAN, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 32'd0);
    send_directed(OP_READ, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_FILL_INDEX, 8'd10, 8'd20, 8'd13, 8'd22, 8'd255, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_READ, 8'd13, 8'd22, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_FILL_RGB, 8'd250, 8'd250, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
                  32'ha5a5_a5a5);
    send_directed(OP_READ, 8'd250, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_FILL_INDEX, 8'd5, 8'd0, 8'd4, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_FILL_RGB, 8'd0, 8'd200, 8'd255, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, '1);
    send_directed(OP_READ, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_RAMP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd128, 8'd1, 32'd0);
    send_directed(OP_READ, 8'd13, 8'd22, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_READ, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_directed(OP_UNUSED_FIRST, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 32'd1);
    send_directed(OP_UNUSED_LAST, '1, '1, '1, '1, '1, '1, '1, '1, '1);
    send_directed(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);

    for (int p = 0; p < PHASES; p++) begin
      set_index_store(p % 2 == 0);
      sender_idles = (p != 2);
      if (p == 1) begin
        // Clearing with the index store off must leave the indices in place.
        it = random_item();
        it.operation = OP_CLEAR;
        issue_item(it);
      end
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) issue_item(random_item());
    end

    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    book.flag_leftovers();
    $display("Run covered %0d items including %0d reads over %0d index store settings,",
             items_sent, book.reads_noted, settings_written);
    $display("with every operation code, empty and full-screen fills, ramps and clears.");
    if (book.mismatches == 0) begin
      $display("palette_framebuffer_engine: match");
    end else begin
      $display("palette_framebuffer_engine: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("palette_framebuffer_engine: mismatch");
    $finish;
  end

endmodule
